// ===== sv/sha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types and constants of the byte-stream SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PAD_MARK = 8'h80;

    // One queued item between the front and the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage
`default_nettype wire

// ===== sv/sha_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher channels
// Valid/ready channels for message items and for digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source(output valid, data_byte, has_byte, last, input ready);
    modport sink(input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source(output valid, digest_word, word_index, last_word, input ready);
    modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== sv/sha256_stream_hasher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words per message.
//
//   Channel | Direction | Payload                               | Handshake
//   i_in    | in        | data_byte[7:0], has_byte, last        | valid/ready
//   o_out   | out       | digest_word[31:0], word_index, last_word | valid/ready
//
// While the engine is idle, bytes are absorbed one per cycle; every 64th byte
// starts the round engine, which runs the compression rounds and then the
// chaining add. Finishing shifts in up to 64 pad bytes per block, one per
// cycle, then one or two compressions, then eight output words. A four-item
// queue lets the input keep going while the engine is busy. Reset is
// synchronous and restores the initial hash state.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);

    sha_in_if u_queue ();

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (u_queue.source)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (u_queue.sink),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== sv/sha_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts message items, drops those that carry neither a byte nor an end
// mark, and queues the rest for the compression engine.
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    sha_in_if.sink   i_in,
    sha_in_if.source o_q
);

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QPTR_W:0]    r_cnt, n_cnt;
    logic               push, pop, in_acc;

    assign i_in.ready  = (r_cnt != QUEUE_DEPTH[QPTR_W:0]);
    assign in_acc      = i_in.valid && i_in.ready;
    // An item with no byte and no end mark has no effect on the hash.
    assign push        = in_acc && (i_in.has_byte || i_in.last);
    assign pop         = o_q.valid && o_q.ready;

    assign o_q.valid     = (r_cnt != '0);
    assign o_q.data_byte = r_q[r_rptr].data_byte;
    assign o_q.has_byte  = r_q[r_rptr].has_byte;
    assign o_q.last      = r_q[r_rptr].last;

    always_comb begin
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{data_byte: i_in.data_byte, has_byte: i_in.has_byte,
                             last: i_in.last};
        end
    end

endmodule
`default_nettype wire

// ===== sv/sha_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher back end
// Shifts bytes into the block register, pads, runs one round per cycle and
// emits the digest words through an output register.
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    sha_in_if.sink    i_q,
    sha_out_if.source o_out
);

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        f_bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        f_bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        f_ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        f_ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    t_state        r_state, n_state;
    logic [511:0]  r_blk;
    logic [5:0]    r_fill;
    logic [63:0]   r_bits;
    logic [31:0]   r_chain [8];
    logic [31:0]   r_v [8];
    logic [5:0]    r_rnd;
    logic          r_pend_last, r_padding, r_sent80, r_len_ok, r_final;
    logic [2:0]    r_widx;
    logic          r_ovld;
    logic [31:0]   r_oword;
    logic [2:0]    r_oidx;
    logic          r_olast;

    logic          q_acc, wr_en, load_out, start_pad;
    logic [7:0]    wr_byte, pad_byte, len_byte;
    logic [31:0]   t1, t2, w_new;

    assign q_acc = i_q.valid && i_q.ready;

    assign len_byte = 8'(r_bits >> {~r_fill[2:0], 3'b000});

    always_comb begin
        if (!r_sent80) begin
            pad_byte = PAD_MARK;
        end else if (r_len_ok && (r_fill >= 6'd56)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Round datapath; the block register doubles as the schedule window.
    always_comb begin
        t1 = r_v[7] + f_bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + ROUND_K[r_rnd] + r_blk[511:480];
        t2 = f_bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = r_blk[511:480] + f_ssig0(r_blk[479:448]) + r_blk[223:192]
              + f_ssig1(r_blk[63:32]);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (q_acc) begin
                    if (i_q.has_byte && (r_fill == 6'd63)) begin
                        n_state = ST_COMP;
                    end else if (i_q.last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_padding) begin
                    n_state = r_final ? ST_EMIT : ST_PAD;
                end else begin
                    n_state = r_pend_last ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (r_fill == 6'd63) begin
                    n_state = ST_COMP;
                end
            end
            ST_EMIT: begin
                if (load_out && (r_widx == 3'd7)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        i_q.ready = 1'b0;
        wr_en     = 1'b0;
        wr_byte   = pad_byte;
        load_out  = 1'b0;
        start_pad = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_q.ready = 1'b1;
                wr_en     = q_acc && i_q.has_byte;
                wr_byte   = i_q.data_byte;
                start_pad = q_acc && i_q.last
                          && !(i_q.has_byte && (r_fill == 6'd63));
            end
            ST_ADD: begin
                start_pad = !r_padding && r_pend_last;
            end
            ST_PAD: begin
                wr_en = 1'b1;
            end
            ST_EMIT: begin
                load_out = !r_ovld || o_out.ready;
            end
            default: begin
                i_q.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bits      <= '0;
            r_rnd       <= '0;
            r_pend_last <= 1'b0;
            r_padding   <= 1'b0;
            r_sent80    <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
            r_widx      <= '0;
            r_ovld      <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= HASH_IV[i];
            end
        end else begin
            r_state <= n_state;
            if (q_acc) begin
                r_pend_last <= i_q.last;
                if (i_q.has_byte) begin
                    r_bits <= r_bits + 64'd8;
                end
            end
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (start_pad) begin
                r_padding <= 1'b1;
                r_sent80  <= 1'b0;
                r_len_ok  <= 1'b0;
                r_final   <= 1'b0;
            end
            if (r_state == ST_PAD) begin
                if (!r_sent80) begin
                    r_sent80 <= 1'b1;
                    r_len_ok <= (r_fill < 6'd56);
                end
                if (r_fill == 6'd63) begin
                    r_final <= r_sent80 && r_len_ok;
                end
            end
            if (n_state == ST_COMP && r_state != ST_COMP) begin
                r_rnd <= '0;
            end else if (r_state == ST_COMP) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
                if (r_padding && !r_final) begin
                    r_len_ok <= 1'b1;
                end
            end
            if (load_out) begin
                r_ovld <= 1'b1;
                r_widx <= r_widx + 3'd1;
                if (r_widx == 3'd7) begin
                    // The message is done; start over from the initial values.
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= HASH_IV[i];
                    end
                    r_bits      <= '0;
                    r_fill      <= '0;
                    r_padding   <= 1'b0;
                    r_pend_last <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_blk <= {r_blk[503:0], wr_byte};
        end else if (r_state == ST_COMP) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (n_state == ST_COMP && r_state != ST_COMP) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (r_state == ST_COMP) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (load_out) begin
            r_oword <= r_chain[r_widx];
            r_oidx  <= r_widx;
            r_olast <= (r_widx == 3'd7);
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.digest_word = r_oword;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = r_olast;

endmodule
`default_nettype wire

// ===== sv/sha_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher checker
// Checks the digest word sequence seen on the output port.
// ----------------------------------------------------------------------------
module sha_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_word,
    input wire [2:0]  i_idx,
    input wire        i_last
);

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_word) && $stable(i_idx))
        else $error("digest word changed while stalled");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_idx == 3'd7)))
        else $error("last_word does not match word_index");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=>
            !i_out_valid || (i_idx == $past(i_idx) + 3'd1))
        else $error("digest word skipped or repeated");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind sha256_stream_hasher_unit sha_chk u_sha_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_word      (o_out.digest_word),
    .i_idx       (o_out.word_index),
    .i_last      (o_out.last_word)
);
`default_nettype wire
